/* rtl/ultrasonic_echo_ranger_defines.svh */
// Assertion macros for the ultrasonic echo ranger checker.
// Used only by files that bind checkers to the ranger.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Check on every clock edge outside reset.
`define UER_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define UER_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/uer_pkg.sv */
// Shared types and constants of the ultrasonic echo ranger.
// No dependencies; imported by every ranger module.
`default_nettype none

package uer_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int TIMEOUT_W   = 20;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
    localparam int PCOUNT_W    = 8;
    localparam int PULSE_W     = 20;
    localparam int DIST_W      = 15;
    localparam int Q16_W       = 16;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = PULSE_W - 1 + Q16_W;
    localparam int DRAW_W      = PROD_W - FRAC_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CMP_WIDTH-1:0] CountMaxExt =
        CMP_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [DRAW_W-1:0] DistMaxExt = DRAW_W'((1 << DIST_W) - 1);
    localparam logic [DIST_W-1:0] DistMax    = DIST_W'((1 << DIST_W) - 1);

    localparam logic [TIMEOUT_W-1:0] TimeoutReset  = TIMEOUT_W'(1000000);
    localparam logic [PCOUNT_W-1:0]  TrigWidthReset = PCOUNT_W'(10);
    localparam logic [PCOUNT_W-1:0]  SettleReset    = PCOUNT_W'(2);
    localparam logic [Q16_W-1:0]     Q16Reset       = Q16_W'(2252);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_TRIG,
        PH_WAIT,
        PH_HIGH
    } t_phase;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } t_in;

    typedef struct packed {
        logic               trigger_out;
        logic               busy_res;
        logic               done_res;
        logic               timed_out;
        logic [PULSE_W-1:0] pulse_us;
        logic [DIST_W-1:0]  distance_cm;
    } t_out;

    typedef struct packed {
        logic               trigger_out;
        logic               busy_res;
        logic               done_res;
        logic               timed_out;
        logic [PULSE_W-1:0] pulse_us;
    } t_rec;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_us;
        logic [PCOUNT_W-1:0]  trigger_width_us;
        logic [PCOUNT_W-1:0]  settle_us;
        logic [Q16_W-1:0]     cm_per_half_us_q16;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/uer_front.sv */
// Front end of the ranger: takes tick words and runs the measurement sequencer.
// Depends on uer_pkg; feeds one record per tick into uer_queue.
`default_nettype none

module uer_front import uer_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_word,
    input  wire t_cfg i_cfg,
    input  wire logic i_full,
    output logic      o_push,
    output t_rec      o_rec
);

    t_phase               r_phase, n_phase, ph_eff;
    logic [PCOUNT_W-1:0]  r_pcount, n_pcount, cnt_eff, cnt_inc, width_eff;
    logic [COUNT_WIDTH-1:0] r_wait, n_wait;
    logic [PULSE_W-1:0]   r_high, n_high;
    logic [CMP_WIDTH-1:0] wait_ext, tout_ext, limit_ext;
    logic                 accept, tout_hit;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept;

    always_comb begin
        if (r_phase == PH_IDLE && i_word.start_req) begin
            ph_eff  = (i_cfg.settle_us == '0) ? PH_TRIG : PH_SETTLE;
            cnt_eff = '0;
        end else begin
            ph_eff  = r_phase;
            cnt_eff = r_pcount;
        end
        cnt_inc   = cnt_eff + PCOUNT_W'(1);
        width_eff = (i_cfg.trigger_width_us == '0) ? PCOUNT_W'(1) : i_cfg.trigger_width_us;
        wait_ext  = CMP_WIDTH'(r_wait);
        tout_ext  = CMP_WIDTH'(i_cfg.timeout_us);
        limit_ext = (tout_ext < CountMaxExt) ? tout_ext : CountMaxExt;
        tout_hit  = wait_ext >= limit_ext;
    end

    always_comb begin
        n_phase  = r_phase;
        n_pcount = r_pcount;
        n_wait   = r_wait;
        n_high   = r_high;
        if (accept) begin
            unique case (ph_eff)
                PH_SETTLE: begin
                    n_phase  = ph_eff;
                    n_pcount = cnt_inc;
                    if (cnt_inc >= i_cfg.settle_us) begin
                        n_phase  = PH_TRIG;
                        n_pcount = '0;
                    end
                end
                PH_TRIG: begin
                    n_phase  = ph_eff;
                    n_pcount = cnt_inc;
                    if (cnt_inc >= width_eff) begin
                        n_phase  = PH_WAIT;
                        n_pcount = '0;
                        n_wait   = '0;
                        n_high   = '0;
                    end
                end
                PH_WAIT, PH_HIGH: begin
                    if (ph_eff == PH_HIGH && !i_word.echo_level) begin
                        n_phase = PH_IDLE;
                    end else if (tout_hit) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_wait = r_wait + COUNT_WIDTH'(1);
                        if (i_word.echo_level) begin
                            n_high  = r_high + PULSE_W'(1);
                            n_phase = PH_HIGH;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_rec = '0;
        unique case (ph_eff)
            PH_SETTLE: begin
                o_rec.busy_res = 1'b1;
            end
            PH_TRIG: begin
                o_rec.busy_res    = 1'b1;
                o_rec.trigger_out = 1'b1;
            end
            PH_WAIT, PH_HIGH: begin
                o_rec.busy_res = 1'b1;
                if (ph_eff == PH_HIGH && !i_word.echo_level) begin
                    o_rec.done_res = 1'b1;
                    o_rec.pulse_us = r_high;
                end else if (tout_hit) begin
                    o_rec.done_res  = 1'b1;
                    o_rec.timed_out = 1'b1;
                end
            end
            default: begin
                o_rec = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pcount <= '0;
            r_wait   <= '0;
            r_high   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pcount <= n_pcount;
            r_wait   <= n_wait;
            r_high   <= n_high;
        end
    end

endmodule

`default_nettype wire

/* rtl/uer_queue.sv */
// Short record queue between the ranger front end and back end.
// Depends on uer_pkg for the record type and depth.
`default_nettype none

module uer_queue import uer_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rec i_rec,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_rec      o_rec
);

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

`default_nettype wire

/* rtl/uer_back.sv */
// Back end of the ranger: scales pulse length to distance and drives the output word.
// Depends on uer_pkg; takes records from uer_queue.
`default_nettype none

module uer_back import uer_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_rec             i_rec,
    output logic                  o_pop,
    input  wire logic [Q16_W-1:0] i_q16,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_out                  o_word
);

    logic              r_s1_valid;
    t_rec              r_s1_rec;
    logic [PROD_W-1:0] r_s1_prod;
    logic              r_out_valid;
    t_out              r_out;
    logic [DIST_W-1:0] r_last, n_last, dist_sat;
    logic [DRAW_W-1:0] dist_raw;
    logic              out_free, s1_free;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_pop    = i_valid && s1_free;
    assign o_valid  = r_out_valid;
    assign o_word   = r_out;

    always_comb begin
        dist_raw = r_s1_prod[PROD_W-1:FRAC_W];
        dist_sat = (dist_raw > DistMaxExt) ? DistMax : dist_raw[DIST_W-1:0];
        n_last   = r_last;
        if (r_s1_rec.done_res) begin
            n_last = r_s1_rec.timed_out ? '0 : dist_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_rec  <= i_rec;
            r_s1_prod <= PROD_W'(i_rec.pulse_us[PULSE_W-1:1]) * PROD_W'(i_q16);
        end
        if (r_s1_valid && out_free) begin
            r_out.trigger_out <= r_s1_rec.trigger_out;
            r_out.busy_res    <= r_s1_rec.busy_res;
            r_out.done_res    <= r_s1_rec.done_res;
            r_out.timed_out   <= r_s1_rec.timed_out;
            r_out.pulse_us    <= r_s1_rec.pulse_us;
            r_out.distance_cm <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (r_s1_valid && out_free) begin
                r_last <= n_last;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger: configuration registers, sequencer, queue and distance back end.
// Depends on uer_pkg, uer_front, uer_queue and uer_back.
//
// Usage: present one word per microsecond tick on i_word (start_req, echo_level)
// with i_valid; a word is taken on a clock edge with i_valid high and o_stall low.
// Every taken word yields exactly one result word on o_word (trigger level, busy,
// done, timeout flag, pulse length, last distance), taken on an edge with o_valid
// high and i_stall low. Results come out in order, each word passing through the queue,
// the multiply stage and the output register before o_valid rises. One word per cycle
// is sustained while i_stall stays low, through the two-stage back end (multiply,
// then saturate). Stalling the output fills the four-entry queue; once full,
// o_stall rises and holds input until words drain. Registers are written
// through i_cfg_we, i_cfg_idx and i_cfg_data; the user must write them only while
// no measurement word is in flight, and the block itself does not enforce this.
// Synchronous reset (i_rst_n low) returns the sequencer to idle, empties the
// queue and pipeline, clears the stored distance and restores the register
// defaults (timeout 1000000, trigger width 10, settle 2, scale 2252).
`default_nettype none

module ultrasonic_echo_ranger import uer_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in                   i_word,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out                       o_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic q_full, q_push, q_valid, q_pop;
    t_rec f_rec, q_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_us         <= TimeoutReset;
            r_cfg.trigger_width_us   <= TrigWidthReset;
            r_cfg.settle_us          <= SettleReset;
            r_cfg.cm_per_half_us_q16 <= Q16Reset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT:    r_cfg.timeout_us         <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_TRIG_WIDTH: r_cfg.trigger_width_us   <= i_cfg_data[PCOUNT_W-1:0];
                CFG_SETTLE:     r_cfg.settle_us          <= i_cfg_data[PCOUNT_W-1:0];
                CFG_SCALE:      r_cfg.cm_per_half_us_q16 <= i_cfg_data[Q16_W-1:0];
                default: begin
                end
            endcase
        end
    end

    uer_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_rec   (f_rec)
    );

    uer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (f_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rec   (q_rec)
    );

    uer_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_rec   (q_rec),
        .o_pop   (q_pop),
        .i_q16   (r_cfg.cm_per_half_us_q16),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

endmodule

`default_nettype wire

/* rtl/uer_checker.sv */
// Port-level checks on the ultrasonic echo ranger, bound to its top level.
// Depends on uer_pkg and ultrasonic_echo_ranger_defines.svh.
`default_nettype none
`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker import uer_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_out o_word
);

    logic tout_clean, done_clean;

    assign tout_clean = o_word.done_res && o_word.pulse_us == '0 && o_word.distance_cm == '0;
    assign done_clean = o_word.busy_res && !o_word.trigger_out;

    `UER_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_word), "stalled word changed")
    `UER_ASSERT(a_tout_zero, o_valid && o_word.timed_out |-> tout_clean, "timeout word has data")
    `UER_ASSERT(a_done_busy, o_valid && o_word.done_res |-> done_clean, "done word outside a measurement")
    `UER_ASSERT(a_trig_busy, o_valid && o_word.trigger_out |-> o_word.busy_res, "trigger while not busy")
    `UER_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_valid && !o_stall, "output or stall after reset")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

`default_nettype wire
